FILE: design/lcd_marquee_scroller_defines.svh
// Assertion macros used by the marquee scroller sequencer
`ifndef LCD_MARQUEE_SCROLLER_DEFINES_SVH
`define LCD_MARQUEE_SCROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LMS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define LMS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lms_pkg.sv
// Types and constants for the marquee scroller
package lms_pkg;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_APPEND = 3'd1,
    FUNC_FINISH = 3'd2,
    FUNC_TICK   = 3'd3,
    FUNC_PAUSE  = 3'd4,
    FUNC_RESUME = 3'd5
  } lms_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_CURSOR,
    ST_CHARS
  } lms_state_t;

  typedef struct packed {
    lms_func_t  func;
    logic [7:0] char_byte;
  } lms_in_t;

  typedef struct packed {
    logic       cmd_or_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lms_out_t;

  typedef struct packed {
    logic       row;
    logic [3:0] col;
    logic [4:0] width;
  } lms_cfg_t;

  localparam logic [1:0] CFG_START_ROW    = 2'd0;
  localparam logic [1:0] CFG_START_COL    = 2'd1;
  localparam logic [1:0] CFG_WINDOW_WIDTH = 2'd2;

  localparam logic [4:0] WINDOW_WIDTH_RST = 5'd16;

  localparam logic [7:0] CURSOR_BASE    = 8'h80;
  localparam logic [7:0] ROW_STEP       = 8'h40;
  localparam logic [7:0] SECOND_ROW_CMD = 8'hC0;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;

endpackage

FILE: design/lms_store.sv
// Message character store: one write port, one registered read port
module lms_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lms_ctrl.sv
// Sequencer: message bookkeeping, fill and tick runs with one shared position stepper
`include "lcd_marquee_scroller_defines.svh"

module lms_ctrl
  import lms_pkg::*;
#(
  parameter int MSG_DEPTH  = 128,
  parameter int LINE_CHARS = 16,
  parameter int AW         = $clog2(MSG_DEPTH),
  parameter int LW         = $clog2(MSG_DEPTH + 1),
  parameter int CW         = $clog2(LINE_CHARS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  lms_in_t       in_data,
  input  lms_cfg_t      cfg,
  output logic          busy,
  output logic          out_strobe,
  output lms_out_t      out_data,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam logic [7:0]    LINE_W   = 8'(LINE_CHARS);
  localparam logic [LW-1:0] APP_MAX  = LW'(MSG_DEPTH - 3);
  localparam logic [LW-1:0] LEN_MAX  = LW'(MSG_DEPTH);

  lms_state_t    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] scroll_r, scroll_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          run_r, run_nxt;
  logic          out_valid_r, out_valid_nxt;
  lms_out_t      out_item_r, out_item_nxt;

  logic          accept;
  logic          tick_go;
  logic [7:0]    col_sum;
  logic [CW-1:0] width_c;
  logic [AW-1:0] scroll_clamp;
  logic [AW-1:0] step_op;
  logic [AW:0]   step_sum;
  logic [AW-1:0] step_out;

  assign accept  = start && (state_r == ST_IDLE);
  assign tick_go = accept && (in_data.func == FUNC_TICK) && run_r && (len_r != '0);

  // clamp the window to the visible line
  assign col_sum = 8'(cfg.col) + 8'(cfg.width);
  always_comb begin
    if (8'(cfg.col) >= LINE_W) begin
      width_c = '0;
    end else if (col_sum > LINE_W) begin
      width_c = CW'(LINE_W - 8'(cfg.col));
    end else begin
      width_c = CW'(cfg.width);
    end
  end

  assign scroll_clamp = ((AW+1)'(scroll_r) >= (AW+1)'(len_r)) ? '0 : scroll_r;

  // shared position stepper: advance by one, wrap at message length
  assign step_op  = (state_r == ST_IDLE) ? scroll_clamp : pos_r;
  assign step_sum = (AW+1)'(step_op) + (AW+1)'(1);
  assign step_out = (step_sum >= (AW+1)'(len_r)) ? '0 : step_sum[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.func == FUNC_FINISH)) begin
          state_nxt = ST_FILL;
        end else if (tick_go) begin
          state_nxt = ST_CURSOR;
        end
      end
      ST_FILL: begin
        if (fill_r == 2'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CURSOR: begin
        state_nxt = (cnt_r == '0) ? ST_IDLE : ST_CHARS;
      end
      ST_CHARS: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_nxt       = len_r;
    scroll_nxt    = scroll_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    run_nxt       = run_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = len_r[AW-1:0];
    mem_wdata     = in_data.char_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FUNC_CLEAR: begin
              len_nxt    = '0;
              scroll_nxt = '0;
            end
            FUNC_APPEND: begin
              if (len_r < APP_MAX) begin
                mem_we  = 1'b1;
                len_nxt = len_r + LW'(1);
              end
            end
            FUNC_FINISH: begin
              fill_nxt   = 2'd3;
              scroll_nxt = '0;
            end
            FUNC_TICK: begin
              if (tick_go) begin
                pos_nxt    = scroll_clamp;
                scroll_nxt = step_out;
                cnt_nxt    = width_c;
              end
            end
            FUNC_PAUSE:  run_nxt = 1'b0;
            FUNC_RESUME: run_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_wdata = SPACE_CHAR;
        if (len_r < LEN_MAX) begin
          mem_we  = 1'b1;
          len_nxt = len_r + LW'(1);
        end
        fill_nxt = fill_r - 2'd1;
      end
      ST_CURSOR: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.cmd_or_data = 1'b0;
        out_item_nxt.lcd_byte    = CURSOR_BASE + (cfg.row ? ROW_STEP : 8'h00) + 8'(cfg.col);
        out_item_nxt.last        = (cnt_r == '0);
        pos_nxt                  = step_out;
      end
      ST_CHARS: begin
        out_valid_nxt = 1'b1;
        if (mem_rdata == NEWLINE_CHAR) begin
          out_item_nxt.cmd_or_data = 1'b0;
          out_item_nxt.lcd_byte    = SECOND_ROW_CMD;
        end else begin
          out_item_nxt.cmd_or_data = 1'b1;
          out_item_nxt.lcd_byte    = mem_rdata;
        end
        out_item_nxt.last = (cnt_r == CW'(1));
        pos_nxt           = step_out;
        cnt_nxt           = cnt_r - CW'(1);
      end
      default: ;
    endcase
  end

  // read runs one address ahead of the emitted character
  assign mem_raddr = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      scroll_r    <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      run_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      scroll_r    <= scroll_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_item_r;

  `LMS_CHECK_NEXT(a_tick_enters_cursor, tick_go, state_r == ST_CURSOR, "tick did not start a run")
  `LMS_CHECK_NEXT(a_cursor_emits_cmd, state_r == ST_CURSOR,
                  out_valid_r && !out_item_r.cmd_or_data, "cursor command missing")
  `LMS_CHECK(a_len_bound, 1'b1, len_r <= LEN_MAX, "message length beyond store depth")
  `LMS_CHECK(a_chars_count, state_r == ST_CHARS, cnt_r != '0, "character run with zero count")
  `LMS_CHECK(a_pos_in_msg, state_r == ST_CURSOR || state_r == ST_CHARS,
             (AW+1)'(pos_r) < (AW+1)'(len_r), "read position outside message")

endmodule

FILE: design/lcd_marquee_scroller.sv
// Marquee scroller top level: configuration registers, store and sequencer
// A tick's cursor command passes the CURSOR state and the output register, then one byte
//   per cycle follows; a tick with window W emits the command and W bytes (W <= LINE_CHARS).
// Finish does up to three store writes while filling; clear, append, pause, resume stay idle.
// Rate is set by the store read port and the position stepper: one character a cycle.
// Synchronous active-low reset: empty message, start at 0, running, window 16 at row 0 col 0.
// Results are strobed for one cycle; the receiver has no backpressure.
module lcd_marquee_scroller
  import lms_pkg::*;
#(
  parameter int MSG_DEPTH  = 128,
  parameter int LINE_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // item channel
  input  logic       start,
  input  lms_in_t    in_data,
  output logic       busy,
  // result channel
  output logic       out_strobe,
  output lms_out_t   out_data,
  // configuration port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int AW = $clog2(MSG_DEPTH);

  lms_cfg_t      cfg_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Config registers; writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row   <= 1'b0;
      cfg_r.col   <= 4'd0;
      cfg_r.width <= WINDOW_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_ROW:    cfg_r.row   <= cfg_wdata[0];
        CFG_START_COL:    cfg_r.col   <= cfg_wdata[3:0];
        CFG_WINDOW_WIDTH: cfg_r.width <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Message characters; entries above the length are never read.
  lms_store #(
    .DEPTH (MSG_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: one item at a time, busy until its run is done.
  lms_ctrl #(
    .MSG_DEPTH  (MSG_DEPTH),
    .LINE_CHARS (LINE_CHARS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

FILE: tb/tb_lcd_marquee_scroller.sv
// Self-checking testbench for the LCD marquee scroller: directed and random items, scoreboard
module tb_lcd_marquee_scroller;
  import lms_pkg::*;

  localparam int MSG_DEPTH     = 128;
  localparam int LINE_CHARS    = 16;
  // Longest tick is cursor + LINE_CHARS bytes; leave margin for pipeline drain
  localparam int SETTLE_CYCLES = LINE_CHARS + 8;
  // No accept, no strobe, no config write for this long means the DUT hung
  localparam int STALL_LIMIT   = 2000;
  // func encodings the block must ignore
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  lms_in_t    in_data = '0;
  logic       busy;
  logic       out_strobe;
  lms_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_START_ROW;
  logic [4:0] cfg_wdata = '0;

  lcd_marquee_scroller #(
    .MSG_DEPTH (MSG_DEPTH),
    .LINE_CHARS(LINE_CHARS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the message store, scroll position,
  // run flag and window registers.
  // ---------------------------------------------------------------------------
  logic [7:0] msg_mem [MSG_DEPTH];
  int         msg_len;
  int         scroll_pos;
  logic       scroll_on;
  logic       cfg_row;
  logic [3:0] cfg_col;
  logic [4:0] cfg_width;

  lms_in_t  items_to_send [$];   // fed by the initial block, drained by the driver
  lms_out_t lcd_bytes_due [$];   // display bytes the DUT still owes us
  int       mismatch_count = 0;
  int       idle_pct = 14;       // sender gap rate, percent of slots
  int       stall_cycles = 0;

  function automatic void reset_predictor();
    foreach (msg_mem[i]) msg_mem[i] = '0;
    msg_len    = 0;
    scroll_pos = 0;
    scroll_on  = 1'b1;
    cfg_row    = 1'b0;
    cfg_col    = '0;
    cfg_width  = WINDOW_WIDTH_RST;
  endfunction

  // Apply one accepted item; a tick queues cursor command plus window bytes.
  function automatic void predict_lcd_bytes(input lms_in_t item);
    logic [2:0] code;
    int         shown;
    int         pos;
    logic [7:0] ch;
    lms_out_t   res;
    code = item.func;
    case (code)
      FUNC_CLEAR: begin
        msg_len    = 0;
        scroll_pos = 0;
      end
      FUNC_APPEND: begin
        // three slots stay reserved for the finish padding
        if (msg_len < MSG_DEPTH - 3) begin
          msg_mem[msg_len] = item.char_byte;
          msg_len++;
        end
      end
      FUNC_FINISH: begin
        repeat (3) begin
          if (msg_len < MSG_DEPTH) begin
            msg_mem[msg_len] = SPACE_CHAR;
            msg_len++;
          end
        end
        scroll_pos = 0;
      end
      FUNC_PAUSE:  scroll_on = 1'b0;
      FUNC_RESUME: scroll_on = 1'b1;
      FUNC_TICK: begin
        // paused or empty: silent, nothing moves
        if (scroll_on && msg_len != 0) begin
          // window may not run past the right edge of the line
          if (int'(cfg_col) + int'(cfg_width) > LINE_CHARS) shown = LINE_CHARS - int'(cfg_col);
          else shown = int'(cfg_width);
          res.cmd_or_data = 1'b0;
          res.lcd_byte    = CURSOR_BASE + (cfg_row ? ROW_STEP : 8'h00) + {4'h0, cfg_col};
          res.last        = (shown == 0);
          lcd_bytes_due.push_back(res);
          if (scroll_pos >= msg_len) scroll_pos = 0;
          pos = scroll_pos;
          for (int k = 0; k < shown; k++) begin
            ch = msg_mem[pos];
            // newline in the window turns into a jump to row two
            res.cmd_or_data = (ch != NEWLINE_CHAR);
            res.lcd_byte    = (ch == NEWLINE_CHAR) ? SECOND_ROW_CMD : ch;
            res.last        = (k == shown - 1);
            lcd_bytes_due.push_back(res);
            pos++;
            if (pos >= msg_len) pos = 0;
          end
          scroll_pos++;
          if (scroll_pos >= msg_len) scroll_pos = 0;
        end
      end
      default: ;  // spare encodings are no-ops
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next queued item unless it
  // picks a random gap.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_lcd_bytes(in_data);
      // slot is free when nothing is offered or the offer was just taken
      if (!start || !busy) begin
        if (items_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          in_data <= items_to_send.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed byte must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lms_out_t want;
    if (rst_n && out_strobe) begin
      if (lcd_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got rs=%0b byte=%02h last=%0b",
                 $time, out_data.cmd_or_data, out_data.lcd_byte, out_data.last);
        mismatch_count++;
      end else begin
        want = lcd_bytes_due.pop_front();
        if (out_data.cmd_or_data !== want.cmd_or_data) begin
          $display("%0t: cmd_or_data mismatch, expected %0b, got %0b",
                   $time, want.cmd_or_data, out_data.cmd_or_data);
          mismatch_count++;
        end
        if (out_data.lcd_byte !== want.lcd_byte) begin
          $display("%0t: lcd_byte mismatch, expected %02h, got %02h",
                   $time, want.lcd_byte, out_data.lcd_byte);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any handshake, strobe or register write counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(input logic [2:0] code, input logic [7:0] ch);
    lms_in_t item;
    item.func      = lms_func_t'(code);
    item.char_byte = ch;
    items_to_send.push_back(item);
  endfunction

  // Message text: mostly arbitrary bytes, with newlines and spaces mixed in
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return NEWLINE_CHAR;
    if (roll < 20) return SPACE_CHAR;
    return 8'($urandom_range(255));
  endfunction

  // Block until every item is taken, every byte seen and the DUT has gone
  // quiet; items like append leave no result to wait on, hence the settle.
  task automatic wait_drained();
    while (items_to_send.size() != 0 || start || busy || lcd_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while drained, so the predictor may take the new values at once
  task automatic write_window(input logic row, input logic [3:0] col, input logic [4:0] width);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_ROW;
    cfg_wdata <= {4'h0, row};
    @(posedge clk);
    cfg_index <= CFG_START_COL;
    cfg_wdata <= {1'b0, col};
    @(posedge clk);
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_row   = row;
    cfg_col   = col;
    cfg_width = width;
  endtask

  // Random batch: mostly a build-then-scroll sequence with random content,
  // the rest raw noise. Spare encodings are not counted toward the batch.
  task automatic queue_random_batch(input int count);
    int added;
    int n_chars;
    int n_ticks;
    logic [2:0] code;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(3) != 0) begin
          queue_item(FUNC_CLEAR, 8'($urandom_range(255)));
          added++;
        end
        n_chars = $urandom_range(1, 12);
        repeat (n_chars) begin
          queue_item(FUNC_APPEND, pick_char());
          added++;
        end
        if ($urandom_range(1) != 0) begin
          queue_item(FUNC_FINISH, 8'($urandom_range(255)));
          added++;
        end
        n_ticks = $urandom_range(2, 6);
        repeat (n_ticks) begin
          // occasional pause/resume around a tick
          if ($urandom_range(9) == 0) begin
            queue_item(FUNC_PAUSE, 8'($urandom_range(255)));
            queue_item(FUNC_TICK, 8'($urandom_range(255)));
            queue_item(FUNC_RESUME, 8'($urandom_range(255)));
            added += 3;
          end
          queue_item(FUNC_TICK, 8'($urandom_range(255)));
          added++;
        end
      end else begin
        code = 3'($urandom_range(7));
        queue_item(code, 8'($urandom_range(255)));
        if (code != FUNC_SPARE6 && code != FUNC_SPARE7) added++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset window (row 0, col 0, width 16), edge bytes, all funcs
    idle_pct = 14;
    queue_item(FUNC_TICK, 8'h00);      // empty message: silent
    queue_item(FUNC_APPEND, 8'h41);
    queue_item(FUNC_TICK, 8'hFF);      // one char wraps across the whole window
    queue_item(FUNC_APPEND, NEWLINE_CHAR);
    queue_item(FUNC_APPEND, 8'hFF);
    queue_item(FUNC_APPEND, 8'h00);
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_PAUSE, 8'h00);
    queue_item(FUNC_TICK, 8'h00);      // paused: silent, no advance
    queue_item(FUNC_RESUME, 8'hFF);
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_FINISH, 8'h00);    // pads and rewinds scroll
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_SPARE6, 8'hFF);
    queue_item(FUNC_SPARE7, 8'h00);
    queue_item(FUNC_CLEAR, 8'hFF);
    queue_item(FUNC_TICK, 8'h00);      // cleared: silent
    queue_item(FUNC_APPEND, 8'h55);
    queue_item(FUNC_APPEND, 8'hAA);
    queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_TICK, 8'hFF);
    // sender holds here until every byte has come back
    wait_drained();

    // Bottom-right corner: width clamps to a single character
    write_window(1'b1, 4'd15, 5'd16);
    queue_random_batch(8);
    wait_drained();

    // Zero window: cursor command alone carries last
    write_window(1'b0, 4'd0, 5'd0);
    queue_random_batch(8);
    wait_drained();

    // Long stretch with no sender gaps, partially clamped window
    idle_pct = 0;
    write_window(1'b1, 4'd5, 5'd16);
    queue_random_batch(16);
    wait_drained();

    // Full store: finishes pad three at a time up to the append limit,
    // further appends are dropped, a finish takes the last three slots and
    // a second finish finds no room for any padding
    idle_pct = 14;
    write_window(1'b0, 4'd0, 5'd16);
    queue_item(FUNC_CLEAR, 8'h00);
    repeat (8) queue_item(FUNC_APPEND, pick_char());
    repeat ((MSG_DEPTH - 3 - 8) / 3) queue_item(FUNC_FINISH, 8'h00);
    repeat (2) queue_item(FUNC_APPEND, pick_char());
    queue_item(FUNC_FINISH, 8'h00);
    repeat (2) queue_item(FUNC_TICK, 8'h00);
    queue_item(FUNC_FINISH, 8'hFF);
    queue_item(FUNC_APPEND, 8'hFF);
    repeat (2) queue_item(FUNC_TICK, 8'h00);
    wait_drained();

    // Random windows anywhere on the display
    repeat (3) begin
      write_window(1'($urandom_range(1)), 4'($urandom_range(15)),
                   5'($urandom_range(LINE_CHARS)));
      queue_random_batch(8);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/lms_pkg.sv
design/lms_store.sv
design/lms_ctrl.sv
design/lcd_marquee_scroller.sv
tb/tb_lcd_marquee_scroller.sv
